### rtl/assert_macros.svh
// assertion macros for the descriptor table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtfl_pkg.sv
// types and constants of the descriptor table with free list
package dtfl_pkg;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 9;
  localparam int FLAGS_W  = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam int ENTRY_W = FLAGS_W + HANDLE_W;

  localparam logic [FLAGS_W-1:0]  PRESENT_BIT    = 8'h01;
  localparam logic [HANDLE_W-1:0] HANDLE_INVALID = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### rtl/dtfl_ram.sv
// generic single-port-write ram with registered read
module dtfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/descriptor_table_free_list.sv
// Descriptor table with linked free list.
// A request is taken only while idle: a registered read of the entry or link ram,
// then the write-back and free head update once the output register is free.
// A finished result waits in the output register while the next request runs.
// Reset: synchronous; a clearing pass over all ENTRIES slots (512 by default) loads
// the reserved entries and the free chain, with s_tready low meanwhile.
module descriptor_table_free_list #(
  parameter int ENTRIES  = 512,
  parameter int RESERVED = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // func[1:0], slot[10:2], entry_flags[18:11], handle_in[34:19], zero pad
  input  logic [dtfl_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot_out[8:0], handle_out[24:9], status[26:25], zero pad
  output logic [dtfl_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import dtfl_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] LINK_END = LW'(ENTRIES);
  localparam logic [LW-1:0] HEAD_RST = (RESERVED < ENTRIES) ? LW'(RESERVED) : LW'(ENTRIES);

  // input fields
  logic [FUNC_W-1:0]   in_func;
  logic [SLOT_W-1:0]   in_slot;
  logic [FLAGS_W-1:0]  in_flags;
  logic [HANDLE_W-1:0] in_handle;
  logic [IW-1:0]       in_idx;
  logic                in_inrange;

  assign in_func    = s_tdata[1:0];
  assign in_slot    = s_tdata[10:2];
  assign in_flags   = s_tdata[18:11];
  assign in_handle  = s_tdata[34:19];
  assign in_idx     = IW'(in_slot);
  assign in_inrange = 32'(in_slot) < ENTRIES;

  // control and request registers
  state_t              state, state_next;
  logic [LW-1:0]       free_head, free_head_next;
  logic [IW-1:0]       clr_idx;
  logic [FUNC_W-1:0]   req_func;
  logic [SLOT_W-1:0]   req_slot;
  logic [HANDLE_W-1:0] req_handle;
  logic                req_inrange;
  logic                req_full;
  logic [IW-1:0]       req_idx;
  logic                head_empty;
  logic                out_free;
  logic                exec_go;

  // result fields
  logic [SLOT_W-1:0]   res_slot;
  logic [HANDLE_W-1:0] res_handle;
  logic [STATUS_W-1:0] res_status;

  // ram ports
  logic                entry_we, entry_re;
  logic [IW-1:0]       entry_waddr, entry_raddr;
  logic [ENTRY_W-1:0]  entry_wdata, entry_rdata;
  logic                link_we, link_re;
  logic [IW-1:0]       link_waddr, link_raddr;
  logic [LW-1:0]       link_wdata, link_rdata;
  logic [FLAGS_W-1:0]  rd_flags;
  logic [HANDLE_W-1:0] rd_handle;

  assign req_idx    = IW'(req_slot);
  assign head_empty = free_head >= LINK_END;
  assign out_free   = !m_tvalid || m_tready;
  assign rd_flags   = entry_rdata[ENTRY_W-1:HANDLE_W];
  assign rd_handle  = entry_rdata[HANDLE_W-1:0];

  // flag and handle store, packed as {flags, handle}
  dtfl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (entry_wdata),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  // free chain links
  dtfl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, ram control and result
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    s_tready       = 1'b0;
    exec_go        = 1'b0;
    entry_we       = 1'b0;
    entry_waddr    = req_idx;
    entry_wdata    = '0;
    entry_re       = 1'b0;
    entry_raddr    = in_idx;
    link_we        = 1'b0;
    link_waddr     = req_idx;
    link_wdata     = free_head;
    link_re        = 1'b0;
    link_raddr     = free_head[IW-1:0];
    res_slot       = req_slot;
    res_handle     = '0;
    res_status     = STAT_OK;
    case (state)
      S_CLEAR: begin
        entry_we    = 1'b1;
        entry_waddr = clr_idx;
        entry_wdata = (32'(clr_idx) < RESERVED) ? {PRESENT_BIT, HANDLE_W'(clr_idx)} : '0;
        link_we     = 1'b1;
        link_waddr  = clr_idx;
        link_wdata  = LW'(clr_idx) + LW'(1);
        if (clr_idx == IW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_EXEC;
          case (in_func)
            FN_ADD: begin
              if (!head_empty) begin
                entry_we    = 1'b1;
                entry_waddr = free_head[IW-1:0];
                entry_wdata = {PRESENT_BIT | in_flags, in_handle};
                link_re     = 1'b1;
              end
            end
            FN_REMOVE, FN_LOOKUP: begin
              entry_re = in_inrange;
            end
            default: begin
            end
          endcase
        end
      end
      S_EXEC: begin
        case (req_func)
          FN_ADD: begin
            if (req_full) begin
              res_slot   = '0;
              res_handle = HANDLE_INVALID;
              res_status = STAT_FULL;
            end else begin
              res_slot   = SLOT_W'(free_head);
              res_handle = req_handle;
            end
          end
          FN_LOOKUP: begin
            res_handle = req_inrange ? rd_handle : HANDLE_INVALID;
          end
          FN_REMOVE: begin
            if (!req_inrange || rd_flags == '0) begin
              res_status = STAT_ABSENT;
            end
          end
          default: begin
          end
        endcase
        if (out_free) begin
          exec_go    = 1'b1;
          state_next = S_IDLE;
          // write-back and head update
          if (req_func == FN_ADD && !req_full) begin
            free_head_next = link_rdata;
          end
          if (req_func == FN_REMOVE && res_status == STAT_OK) begin
            entry_we       = 1'b1;
            entry_wdata    = {{FLAGS_W{1'b0}}, HANDLE_INVALID};
            link_we        = 1'b1;
            free_head_next = LW'(req_idx);
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // free head and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= HEAD_RST;
      clr_idx   <= '0;
    end else begin
      free_head <= free_head_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_func    <= in_func;
      req_slot    <= in_slot;
      req_handle  <= in_handle;
      req_inrange <= in_inrange;
      req_full    <= head_empty;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {{(OUT_TDATA_W - SLOT_W - HANDLE_W - STATUS_W){1'b0}},
                  res_status, res_handle, res_slot};
    end
  end

  // checks
  `ASSERT_IMPL(a_head_range, clk, rst, 1'b1, free_head <= LINK_END,
               "free head beyond end mark")
  `ASSERT_NEXT(a_accept_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC,
               "accepted request did not enter execution")
  `ASSERT_IMPL(a_remove_present, clk, rst,
               state == S_EXEC && req_func == FN_REMOVE && link_we,
               req_inrange && rd_flags != '0, "remove of an absent entry was applied")
  `ASSERT_IMPL(a_clear_blocks, clk, rst, state == S_CLEAR, !s_tready && !exec_go,
               "request taken during clearing pass")

endmodule
